// ===== rtl/core/raycast_column_texel_mapper_assert.svh =====
// Assertion macros used by the raycast column texel mapper back end.
`ifndef RAYCAST_COLUMN_TEXEL_MAPPER_ASSERT_SVH
`define RAYCAST_COLUMN_TEXEL_MAPPER_ASSERT_SVH
`ifndef SYNTH
`define RCTM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rctm assertion failed");
`define RCTM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rctm implication failed");
`else
`define RCTM_ASSERT(lbl, prop)
`define RCTM_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/rctm_pkg.sv =====
// Shared types and constants for the raycast column texel mapper.
package rctm_pkg;
  localparam int SCREEN_ROWS = 512;
  localparam int ROW_SCALE   = 256;
  localparam int HALF_SCALE  = 128;
  localparam int TEX_W       = 11;
  localparam int DIV_BITS    = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    SRC_CEILING = 2'd0,
    SRC_WALL    = 2'd1,
    SRC_FLOOR   = 2'd2
  } src_t;

  localparam logic [1:0] CFG_CEILING_COLOR  = 2'd0;
  localparam logic [1:0] CFG_FLOOR_COLOR    = 2'd1;
  localparam logic [1:0] CFG_TEXTURE_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_TEXTURE_HEIGHT = 2'd3;

  typedef struct packed {
    src_t               src;
    logic [1:0]         sel;
    logic               mirror;
    logic [31:0]        frac;
    logic signed [25:0] d;
    logic [15:0]        lh;
  } item_t;

  typedef struct packed {
    logic [31:0]      ceil_word;
    logic [31:0]      floor_word;
    logic [TEX_W-1:0] width;
    logic [TEX_W-1:0] height;
  } cfg_t;
endpackage

// ===== rtl/core/rctm_front.sv =====
// Front end: accepts pixels, classifies them and forms the texture coordinates.
module rctm_front import rctm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_row,
  input  logic [11:0]        in_wall_start,
  input  logic [11:0]        in_wall_end,
  input  logic [15:0]        in_line_height,
  input  logic               in_hit_side,
  input  logic signed [17:0] in_ray_dir_x,
  input  logic signed [17:0] in_ray_dir_y,
  input  logic [23:0]        in_wall_distance,
  input  logic [23:0]        in_player_pos_x,
  input  logic [23:0]        in_player_pos_y,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item
);
  localparam logic [25:0] ROW_OFS = 26'(SCREEN_ROWS * HALF_SCALE);

  logic               front_v_r, front_v_nxt;
  item_t              item_r, item_nxt;
  logic               accept;
  logic signed [17:0] rd;
  logic signed [42:0] prod;
  logic [15:0]        pos_frac;
  logic [15:0]        lh_eff;
  logic               rdx_pos, rdy_pos;

  assign in_stall = front_v_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = front_v_r && !q_full;
  assign q_item   = item_r;

  always_comb begin
    rdx_pos  = !in_ray_dir_x[17] && (in_ray_dir_x != 18'sd0);
    rdy_pos  = !in_ray_dir_y[17] && (in_ray_dir_y != 18'sd0);
    rd       = in_hit_side ? in_ray_dir_x : in_ray_dir_y;
    pos_frac = in_hit_side ? in_player_pos_x[15:0] : in_player_pos_y[15:0];
    prod     = $signed({1'b0, in_wall_distance}) * rd;
    lh_eff   = (in_line_height == 16'd0) ? 16'd1 : in_line_height;

    if (in_row < in_wall_start) begin
      item_nxt.src = SRC_CEILING;
    end else if (in_row >= in_wall_end) begin
      item_nxt.src = SRC_FLOOR;
    end else begin
      item_nxt.src = SRC_WALL;
    end
    if (in_hit_side) begin
      item_nxt.sel    = rdy_pos ? 2'd1 : 2'd0;
      item_nxt.mirror = in_ray_dir_y[17];
    end else begin
      item_nxt.sel    = rdx_pos ? 2'd3 : 2'd2;
      item_nxt.mirror = rdx_pos;
    end
    // Only the fraction of the hit coordinate matters, so the low word suffices.
    item_nxt.frac = {pos_frac, 16'd0} + prod[31:0];
    item_nxt.d    = $signed(26'(in_row) * 26'(ROW_SCALE) - ROW_OFS
                            + 26'(lh_eff) * 26'(HALF_SCALE));
    item_nxt.lh   = lh_eff;

    if (accept) begin
      front_v_nxt = 1'b1;
    end else if (q_push) begin
      front_v_nxt = 1'b0;
    end else begin
      front_v_nxt = front_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end
endmodule

// ===== rtl/core/rctm_queue.sv =====
// Short item queue between the front end and the back end.
module rctm_queue import rctm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head_item,
  output logic  empty,
  output logic  full
);
  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty     = (cnt_r == QCNT_W'(0));
  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = QCNT_W'(cnt_r + QCNT_W'(push) - QCNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end
endmodule

// ===== rtl/core/rctm_back.sv =====
// Back end: texture column, pipelined texture row division and texel index.
`include "raycast_column_texel_mapper_assert.svh"
module rctm_back import rctm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_pixel_source,
  output logic [31:0] out_flat_color,
  output logic [1:0]  out_texture_select,
  output logic [19:0] out_texel_index
);
  // Stage 0 holds the products, stage 1 the saturation test, then one quotient bit each.
  localparam int NST = DIV_BITS + 2;

  logic [TEX_W-1:0] w_eff, h_eff;
  logic             adv;

  logic             v_r   [NST];
  src_t             src_r [NST];
  logic [1:0]       sel_r [NST];
  logic [TEX_W-1:0] col_r [NST];
  logic             neg_r [NST];
  logic             sat_r [NST];
  logic [35:0]      rem_r [NST];
  logic [TEX_W-1:0] q_r   [NST];
  logic [23:0]      dv_r  [NST];

  logic             v_nxt   [NST];
  src_t             src_nxt [NST];
  logic [1:0]       sel_nxt [NST];
  logic [TEX_W-1:0] col_nxt [NST];
  logic             neg_nxt [NST];
  logic             sat_nxt [NST];
  logic [35:0]      rem_nxt [NST];
  logic [TEX_W-1:0] q_nxt   [NST];
  logic [23:0]      dv_nxt  [NST];

  logic [42:0]      col_prod;
  logic [TEX_W-1:0] col_raw;
  logic [TEX_W-1:0] trow;
  logic [21:0]      idx_prod;

  logic             out_valid_r;
  logic [1:0]       out_src_r, out_src_nxt;
  logic [31:0]      out_flat_r, out_flat_nxt;
  logic [1:0]       out_sel_r, out_sel_nxt;
  logic [19:0]      out_idx_r, out_idx_nxt;

  assign w_eff = (cfg.width == '0) ? TEX_W'(1) : cfg.width;
  assign h_eff = (cfg.height == '0) ? TEX_W'(1) : cfg.height;
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  always_comb begin
    logic [35:0] sh;
    int          k;
    col_prod   = 43'(q_item.frac) * 43'(w_eff);
    col_raw    = col_prod[42:32];
    v_nxt[0]   = q_pop;
    src_nxt[0] = q_item.src;
    sel_nxt[0] = q_item.sel;
    col_nxt[0] = q_item.mirror ? TEX_W'(w_eff - TEX_W'(1) - col_raw) : col_raw;
    neg_nxt[0] = q_item.d[25];
    sat_nxt[0] = 1'b0;
    rem_nxt[0] = 36'(q_item.d[24:0]) * 36'(h_eff);
    q_nxt[0]   = '0;
    dv_nxt[0]  = {q_item.lh, 8'd0};
    for (int j = 1; j < NST; j++) begin
      k          = DIV_BITS + 1 - j;
      sh         = 36'(dv_r[j-1]) << k;
      v_nxt[j]   = v_r[j-1];
      src_nxt[j] = src_r[j-1];
      sel_nxt[j] = sel_r[j-1];
      col_nxt[j] = col_r[j-1];
      neg_nxt[j] = neg_r[j-1];
      dv_nxt[j]  = dv_r[j-1];
      sat_nxt[j] = sat_r[j-1];
      rem_nxt[j] = rem_r[j-1];
      q_nxt[j]   = q_r[j-1];
      if (j == 1) begin
        // A quotient that needs more bits than the texture can hold saturates.
        sat_nxt[j] = rem_r[j-1] >= sh;
      end else if (rem_r[j-1] >= sh) begin
        rem_nxt[j]  = rem_r[j-1] - sh;
        q_nxt[j][k] = 1'b1;
      end
    end

    if (neg_r[NST-1]) begin
      trow = '0;
    end else if (sat_r[NST-1] || (q_r[NST-1] >= h_eff)) begin
      trow = TEX_W'(h_eff - TEX_W'(1));
    end else begin
      trow = q_r[NST-1];
    end
    idx_prod = 22'(trow) * 22'(w_eff);

    out_src_nxt  = src_r[NST-1];
    out_flat_nxt = '0;
    out_sel_nxt  = '0;
    out_idx_nxt  = '0;
    case (src_r[NST-1])
      SRC_CEILING: out_flat_nxt = cfg.ceil_word;
      SRC_FLOOR:   out_flat_nxt = cfg.floor_word;
      SRC_WALL: begin
        out_sel_nxt = sel_r[NST-1];
        out_idx_nxt = 20'(idx_prod + 22'(col_r[NST-1]));
      end
      default: out_flat_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int j = 0; j < NST; j++) begin
        v_r[j] <= 1'b0;
      end
    end else if (adv) begin
      out_valid_r <= v_r[NST-1];
      for (int j = 0; j < NST; j++) begin
        v_r[j] <= v_nxt[j];
      end
    end
    if (adv) begin
      for (int j = 0; j < NST; j++) begin
        src_r[j] <= src_nxt[j];
        sel_r[j] <= sel_nxt[j];
        col_r[j] <= col_nxt[j];
        neg_r[j] <= neg_nxt[j];
        sat_r[j] <= sat_nxt[j];
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
        dv_r[j]  <= dv_nxt[j];
      end
      out_src_r  <= out_src_nxt;
      out_flat_r <= out_flat_nxt;
      out_sel_r  <= out_sel_nxt;
      out_idx_r  <= out_idx_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_source   = out_src_r;
  assign out_flat_color     = out_flat_r;
  assign out_texture_select = out_sel_r;
  assign out_texel_index    = out_idx_r;

  `RCTM_ASSERT_IMPL(a_col_in_range, v_r[0], col_r[0] < w_eff)
  `RCTM_ASSERT_IMPL(a_flat_no_texel, out_valid_r && (out_src_r != SRC_WALL), (out_idx_r == 20'd0) && (out_sel_r == 2'd0))
  `RCTM_ASSERT_IMPL(a_wall_no_color, out_valid_r && (out_src_r == SRC_WALL), out_flat_r == 32'd0)
  `RCTM_ASSERT(a_pop_only_on_adv, q_pop |-> !q_empty && adv)
endmodule

// ===== rtl/core/raycast_column_texel_mapper.sv =====
// Raycast column texel mapper: turns one screen pixel of a raycast column into a
// ceiling colour, a floor colour or a wall texel index. One item is accepted per
// clock while the output is not stalled; an accepted item passes through the
// front-end register, loaded on the accepting edge, the four-entry queue, one
// product stage, twelve divider stages for the texture row (a saturation test and
// eleven quotient bits), and the output register. Configuration must only be
// written while no item is in flight.
module raycast_column_texel_mapper import rctm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_row,
  input  logic [11:0]        in_wall_start,
  input  logic [11:0]        in_wall_end,
  input  logic [15:0]        in_line_height,
  input  logic               in_hit_side,
  input  logic signed [17:0] in_ray_dir_x,
  input  logic signed [17:0] in_ray_dir_y,
  input  logic [23:0]        in_wall_distance,
  input  logic [23:0]        in_player_pos_x,
  input  logic [23:0]        in_player_pos_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_pixel_source,
  output logic [31:0]        out_flat_color,
  output logic [1:0]         out_texture_select,
  output logic [19:0]        out_texel_index
);
  cfg_t  cfg_r, cfg_nxt;
  logic  q_push, q_pop, q_full, q_empty;
  item_t push_item, head_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CEILING_COLOR:  cfg_nxt.ceil_word  = cfg_wdata;
        CFG_FLOOR_COLOR:    cfg_nxt.floor_word = cfg_wdata;
        CFG_TEXTURE_WIDTH:  cfg_nxt.width      = cfg_wdata[TEX_W-1:0];
        CFG_TEXTURE_HEIGHT: cfg_nxt.height     = cfg_wdata[TEX_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ceil_word  <= '0;
      cfg_r.floor_word <= '0;
      cfg_r.width      <= TEX_W'(64);
      cfg_r.height     <= TEX_W'(64);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rctm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_row           (in_row),
    .in_wall_start    (in_wall_start),
    .in_wall_end      (in_wall_end),
    .in_line_height   (in_line_height),
    .in_hit_side      (in_hit_side),
    .in_ray_dir_x     (in_ray_dir_x),
    .in_ray_dir_y     (in_ray_dir_y),
    .in_wall_distance (in_wall_distance),
    .in_player_pos_x  (in_player_pos_x),
    .in_player_pos_y  (in_player_pos_y),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  rctm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  rctm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_empty            (q_empty),
    .q_item             (head_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pixel_source   (out_pixel_source),
    .out_flat_color     (out_flat_color),
    .out_texture_select (out_texture_select),
    .out_texel_index    (out_texel_index)
  );
endmodule
